// ----- src/dpf_pkg.sv -----
// ----------------------------------------------------------------------------
// dpf_pkg
// Shared types and constants for the duplicate packet filter.
// ----------------------------------------------------------------------------
`default_nettype none

package dpf_pkg;

    localparam int ENTRIES_DEF        = 24;
    localparam int LIFE_W             = 7;
    localparam int LIFETIME_START_DEF = 100;
    localparam int ADDR_W             = 32;
    localparam int BYTE_W             = 8;

    // Probe travelling along the cell chain, one cell per cycle.
    typedef struct packed {
        logic              valid;
        logic              insert;  // 0: ageing/match pass, 1: insertion pass
        logic              hit;     // match found (scan) or entry taken (insert)
        logic              dup;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] seq;
        logic [BYTE_W-1:0] kind;
    } t_probe;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INSERT,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ----- src/dpf_cell.sv -----
// ----------------------------------------------------------------------------
// dpf_cell
// One table entry; ages, matches or takes the passing probe, then forwards it.
// ----------------------------------------------------------------------------
`default_nettype none

module dpf_cell #(
    parameter logic [dpf_pkg::LIFE_W-1:0] LIFETIME_START =
        dpf_pkg::LIFE_W'(dpf_pkg::LIFETIME_START_DEF)
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  dpf_pkg::t_probe i_probe,
    output dpf_pkg::t_probe o_probe
);
    import dpf_pkg::*;

    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [BYTE_W-1:0] r_seq,  n_seq;
    logic [BYTE_W-1:0] r_kind, n_kind;
    logic [LIFE_W-1:0] r_life, n_life;
    t_probe            r_probe, n_probe;

    always_comb begin
        n_addr  = r_addr;
        n_seq   = r_seq;
        n_kind  = r_kind;
        n_life  = r_life;
        n_probe = i_probe;
        if (i_probe.valid && !i_probe.hit) begin
            if (!i_probe.insert) begin
                if (r_life != '0) begin
                    if (r_addr == i_probe.addr) begin
                        n_life      = LIFETIME_START;
                        n_probe.hit = 1'b1;
                        if (r_seq == i_probe.seq && r_kind == i_probe.kind) begin
                            n_probe.dup = 1'b1;
                        end else begin
                            n_seq  = i_probe.seq;
                            n_kind = i_probe.kind;
                        end
                    end else begin
                        n_life = r_life - LIFE_W'(1);
                    end
                end
            end else if (r_life == '0) begin
                // first free entry takes the packet
                n_addr      = i_probe.addr;
                n_seq       = i_probe.seq;
                n_kind      = i_probe.kind;
                n_life      = LIFETIME_START;
                n_probe.hit = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_seq  <= n_seq;
        r_kind <= n_kind;
        r_probe.insert <= n_probe.insert;
        r_probe.hit    <= n_probe.hit;
        r_probe.dup    <= n_probe.dup;
        r_probe.addr   <= n_probe.addr;
        r_probe.seq    <= n_probe.seq;
        r_probe.kind   <= n_probe.kind;
        if (!i_rst_n) begin
            r_life        <= '0;
            r_probe.valid <= 1'b0;
        end else begin
            r_life        <= n_life;
            r_probe.valid <= n_probe.valid;
        end
    end

    assign o_probe = r_probe;

endmodule

`default_nettype wire

// ----- src/dpf_ctrl.sv -----
// ----------------------------------------------------------------------------
// dpf_ctrl
// Sequencer: launches the scan and insertion passes and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module dpf_ctrl (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  wire  [dpf_pkg::ADDR_W-1:0]    i_source_addr,
    input  wire  [dpf_pkg::BYTE_W-1:0]    i_sequence_req,
    input  wire  [dpf_pkg::BYTE_W-1:0]    i_packet_kind,
    input  wire  [dpf_pkg::ADDR_W-1:0]    i_gateway_addr,
    output dpf_pkg::t_probe               o_head,
    input  dpf_pkg::t_probe               i_tail,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic                          o_is_duplicate
);
    import dpf_pkg::*;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [BYTE_W-1:0] r_seq,  n_seq;
    logic [BYTE_W-1:0] r_kind, n_kind;
    logic              r_res,  n_res;
    logic              r_out_valid, n_out_valid;
    logic              r_out_dup,   n_out_dup;
    logic              w_gw;
    logic              w_release;

    assign w_gw      = (i_source_addr == i_gateway_addr);
    assign w_release = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = w_gw ? ST_DONE : ST_SCAN;
            ST_SCAN:   if (i_tail.valid) n_state = i_tail.hit ? ST_DONE : ST_INSERT;
            ST_INSERT: if (i_tail.valid) n_state = ST_DONE;
            ST_DONE:   if (w_release) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        o_in_ready  = 1'b0;
        o_head      = '0;
        n_addr      = r_addr;
        n_seq       = r_seq;
        n_kind      = r_kind;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_dup   = r_out_dup;
        if (i_out_ready) n_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                n_addr     = i_source_addr;
                n_seq      = i_sequence_req;
                n_kind     = i_packet_kind;
                n_res      = 1'b0;
                if (i_in_valid && !w_gw) begin
                    o_head.valid = 1'b1;
                    o_head.addr  = i_source_addr;
                    o_head.seq   = i_sequence_req;
                    o_head.kind  = i_packet_kind;
                end
            end
            ST_SCAN: begin
                if (i_tail.valid) begin
                    n_res = i_tail.dup;
                    if (!i_tail.hit) begin
                        o_head.valid  = 1'b1;
                        o_head.insert = 1'b1;
                        o_head.addr   = r_addr;
                        o_head.seq    = r_seq;
                        o_head.kind   = r_kind;
                    end
                end
            end
            ST_INSERT: begin
                if (i_tail.valid) n_res = 1'b0;
            end
            ST_DONE: begin
                if (w_release) begin
                    n_out_valid = 1'b1;
                    n_out_dup   = r_res;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_seq     <= n_seq;
        r_kind    <= n_kind;
        r_res     <= n_res;
        r_out_dup <= n_out_dup;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_is_duplicate = r_out_dup;

endmodule

`default_nettype wire

// ----- src/duplicate_packet_filter_unit.sv -----
// ----------------------------------------------------------------------------
// duplicate_packet_filter_unit
// Duplicate packet suppression cache built as a chain of entry cells.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_in_valid/o_in_ready) carries one received packet per
//    transfer: source address, sequence number and packet type.
//  - Output channel (o_out_valid/i_out_ready) returns one is_duplicate flag
//    per packet, in order.
//  - Config channel (i_cfg_valid/o_cfg_ready) writes the gateway address;
//    always ready, write only while no packet is in flight.
//  - A gateway packet is answered without a pass through the chain, table
//    untouched; its result is registered before the next packet is taken.
//  - Otherwise a probe walks the chain, one cell per cycle: first the
//    ageing/match pass, then the insertion pass when nothing matched. One
//    packet at a time: the next packet is taken only once the result of the
//    last one has been loaded into the output register.
//  - Reset clears every lifetime (all entries free), the gateway address and
//    the control state; stored addresses and values are left as they are.
//  - If the receiver stalls, the result waits in the output register and the
//    next result is held in the sequencer until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module duplicate_packet_filter_unit #(
    parameter int                         ENTRIES        = dpf_pkg::ENTRIES_DEF,
    parameter logic [dpf_pkg::LIFE_W-1:0] LIFETIME_START =
        dpf_pkg::LIFE_W'(dpf_pkg::LIFETIME_START_DEF)
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_ready,
    input  wire  [dpf_pkg::ADDR_W-1:0]  i_source_addr,
    input  wire  [dpf_pkg::BYTE_W-1:0]  i_sequence_req,
    input  wire  [dpf_pkg::BYTE_W-1:0]  i_packet_kind,
    output logic                        o_out_valid,
    input  wire                         i_out_ready,
    output logic                        o_is_duplicate,
    input  wire                         i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire  [dpf_pkg::ADDR_W-1:0]  i_cfg_gateway_addr
);
    import dpf_pkg::*;

    logic [ADDR_W-1:0] r_gateway;
    t_probe            w_probe [ENTRIES+1];

    // gateway register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gateway <= '0;
        end else if (i_cfg_valid) begin
            r_gateway <= i_cfg_gateway_addr;
        end
    end

    assign o_cfg_ready = 1'b1;

    dpf_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_source_addr  (i_source_addr),
        .i_sequence_req (i_sequence_req),
        .i_packet_kind  (i_packet_kind),
        .i_gateway_addr (r_gateway),
        .o_head         (w_probe[0]),
        .i_tail         (w_probe[ENTRIES]),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_is_duplicate (o_is_duplicate)
    );

    // entry 0 sits at the head, so the probe visits entries in table order
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        dpf_cell #(
            .LIFETIME_START (LIFETIME_START)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_probe (w_probe[g]),
            .o_probe (w_probe[g+1])
        );
    end

endmodule

`default_nettype wire
